FILE: src/wsdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam int LEN_W = 25;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OPCODE   = 3'd1;
    localparam logic [2:0] ERR_TOO_LONG = 3'd2;
    localparam logic [2:0] ERR_ORPHAN   = 3'd3;
    localparam logic [2:0] ERR_MID_FRAG = 3'd4;

    // opcodes
    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    // header positions
    localparam logic [3:0] POS_B0      = 4'd0;
    localparam logic [3:0] POS_B1      = 4'd1;
    localparam logic [3:0] POS_EXT64   = 4'd2;
    localparam logic [3:0] POS_EXT16   = 4'd8;
    localparam logic [3:0] POS_EXTLAST = 4'd9;
    localparam logic [3:0] POS_KEY0    = 4'd10;
    localparam logic [3:0] POS_KEYLAST = 4'd13;
    localparam logic [3:0] POS_PAYLOAD = 4'd14;

    // one result request, front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic [3:0] msg_opcode;
        logic       is_control;
        logic       end_of_message;
        logic [2:0] error_code;
    } t_result;

endpackage

FILE: src/wsdf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_parser
// Front end: header parse, length checks, unmask; one byte per cycle.
// ----------------------------------------------------------------------------
module wsdf_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_byte_valid,
    input  logic [7:0]                i_byte,
    input  logic [wsdf_pkg::LEN_W-1:0] i_max_len,
    output logic                      o_res_valid,
    output wsdf_pkg::t_result         o_res
);

    logic [3:0]  r_pos, n_pos;
    logic        r_fin, n_fin;
    logic [3:0]  r_op, n_op;
    logic        r_masked, n_masked;
    logic [63:0] r_len, n_len;
    logic [wsdf_pkg::LEN_W-1:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic        r_frag, n_frag;
    logic [3:0]  r_fop, n_fop;
    logic [wsdf_pkg::LEN_W-1:0] r_ftot, n_ftot;
    logic        r_err, n_err;

    // length check operands
    logic [63:0] w_len;
    logic [wsdf_pkg::LEN_W:0] w_prior, w_room;
    logic        w_too_long;
    logic        w_ctl;
    logic [3:0]  w_msg_op;
    logic        w_do_len, w_do_start;
    logic [wsdf_pkg::LEN_W-1:0] w_rem_dec;

    always_comb begin
        n_pos = r_pos; n_fin = r_fin; n_op = r_op; n_masked = r_masked;
        n_len = r_len; n_rem = r_rem; n_key = r_key; n_frag = r_frag;
        n_fop = r_fop; n_ftot = r_ftot; n_err = r_err;
        o_res_valid = 1'b0;
        o_res = '0;
        w_len = r_len;
        w_do_len = 1'b0;
        w_do_start = 1'b0;
        w_ctl = r_op[3];
        w_msg_op = (r_op == wsdf_pkg::OP_CONT) ? r_fop : r_op;
        w_prior = '0;
        w_room = '0;
        w_too_long = 1'b0;
        w_rem_dec = r_rem - 1'b1;

        if (i_byte_valid && !r_err) begin
            if (r_pos == wsdf_pkg::POS_B0 || r_pos == 4'd15) begin
                // first header byte
                n_fin = i_byte[7];
                n_op  = i_byte[3:0];
                if (!(i_byte[3:0] <= wsdf_pkg::OP_BIN ||
                      (i_byte[3:0] >= wsdf_pkg::OP_CLOSE &&
                       i_byte[3:0] <= wsdf_pkg::OP_PONG))) begin
                    n_err = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.error_code = wsdf_pkg::ERR_OPCODE;
                end else begin
                    n_pos = wsdf_pkg::POS_B1;
                end
            end else if (r_pos == wsdf_pkg::POS_B1) begin
                n_masked = i_byte[7];
                n_len = '0;
                if (i_byte[6:0] == 7'd126) begin
                    n_pos = wsdf_pkg::POS_EXT16;
                end else if (i_byte[6:0] == 7'd127) begin
                    n_pos = wsdf_pkg::POS_EXT64;
                end else begin
                    n_len = {57'd0, i_byte[6:0]};
                    w_len = n_len;
                    w_do_len = 1'b1;
                end
            end else if (r_pos <= wsdf_pkg::POS_EXTLAST) begin
                n_len = {r_len[55:0], i_byte};
                if (r_pos == wsdf_pkg::POS_EXTLAST) begin
                    w_len = n_len;
                    w_do_len = 1'b1;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end else if (r_pos <= wsdf_pkg::POS_KEYLAST) begin
                n_key = {r_key[23:0], i_byte};
                if (r_pos == wsdf_pkg::POS_KEYLAST) begin
                    w_do_start = 1'b1;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end else begin
                // payload byte
                o_res_valid = 1'b1;
                o_res.has_byte = 1'b1;
                o_res.msg_opcode = w_msg_op;
                o_res.is_control = w_ctl;
                o_res.data_byte = r_masked ? (i_byte ^ r_key[31:24]) : i_byte;
                if (r_masked) n_key = {r_key[23:0], r_key[31:24]};
                n_rem = w_rem_dec;
                if (w_rem_dec == '0) begin
                    o_res.end_of_message = w_ctl | r_fin;
                    n_pos = wsdf_pkg::POS_B0;
                    if (r_op == wsdf_pkg::OP_CONT && r_fin) begin
                        n_frag = 1'b0; n_fop = '0; n_ftot = '0;
                    end
                end
            end

            // length known: limit and fragment checks
            if (w_do_len) begin
                if (r_frag && r_op == wsdf_pkg::OP_CONT)
                    w_prior = {1'b0, r_ftot};
                w_room = {1'b0, i_max_len} - w_prior;
                w_too_long = (w_prior > {1'b0, i_max_len}) ||
                             (w_len > {{(64-wsdf_pkg::LEN_W-1){1'b0}}, w_room});
                if (w_too_long) begin
                    n_err = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.error_code = wsdf_pkg::ERR_TOO_LONG;
                end else if (!w_ctl && r_op == wsdf_pkg::OP_CONT && !r_frag) begin
                    n_err = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.error_code = wsdf_pkg::ERR_ORPHAN;
                end else if (!w_ctl && r_op != wsdf_pkg::OP_CONT && r_frag) begin
                    n_err = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.error_code = wsdf_pkg::ERR_MID_FRAG;
                end else begin
                    if (!w_ctl) begin
                        if (r_op == wsdf_pkg::OP_CONT) begin
                            n_ftot = w_prior[wsdf_pkg::LEN_W-1:0] +
                                     w_len[wsdf_pkg::LEN_W-1:0];
                        end else if (!r_fin) begin
                            n_frag = 1'b1;
                            n_fop  = r_op;
                            n_ftot = w_len[wsdf_pkg::LEN_W-1:0];
                        end
                    end
                    if (n_masked) begin
                        n_key = '0;
                        n_pos = wsdf_pkg::POS_KEY0;
                    end else begin
                        w_do_start = 1'b1;
                    end
                end
            end

            // start of payload, or an empty frame
            if (w_do_start) begin
                if (w_len != '0) begin
                    n_rem = w_len[wsdf_pkg::LEN_W-1:0];
                    n_pos = wsdf_pkg::POS_PAYLOAD;
                end else begin
                    n_pos = wsdf_pkg::POS_B0;
                    if (w_ctl || r_fin) begin
                        o_res_valid = 1'b1;
                        o_res.msg_opcode = (r_op == wsdf_pkg::OP_CONT) ? n_fop : r_op;
                        o_res.is_control = w_ctl;
                        o_res.end_of_message = 1'b1;
                    end
                    if (r_op == wsdf_pkg::OP_CONT && r_fin) begin
                        n_frag = 1'b0; n_fop = '0; n_ftot = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_fin <= 1'b0; r_op <= '0; r_masked <= 1'b0;
            r_len <= '0; r_rem <= '0; r_key <= '0; r_frag <= 1'b0;
            r_fop <= '0; r_ftot <= '0; r_err <= 1'b0;
        end else begin
            r_pos <= n_pos; r_fin <= n_fin; r_op <= n_op; r_masked <= n_masked;
            r_len <= n_len; r_rem <= n_rem; r_key <= n_key; r_frag <= n_frag;
            r_fop <= n_fop; r_ftot <= n_ftot; r_err <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err) else $error("error flag cleared");
    a_no_res_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_res_valid) else $error("result after error");
    a_err_res_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error_code != wsdf_pkg::ERR_NONE) |-> !o_res.has_byte)
        else $error("error result carries a byte");
`endif

endmodule

FILE: src/wsdf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_queue
// Four-entry result queue between parser and output; reports free space.
// ----------------------------------------------------------------------------
module wsdf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  wsdf_pkg::t_result i_wr_data,
    output logic              o_valid,
    input  logic              i_rd,
    output wsdf_pkg::t_result o_rd_data,
    output logic              o_space
);

    wsdf_pkg::t_result r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_valid   = (r_cnt != 3'd0);
    assign o_rd_data = r_mem[r_rp];
    // one slot kept back for the request already in flight
    assign o_space   = (r_cnt < 3'd3);

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 2'd1;
            if (i_rd && o_valid) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_wr} - {2'd0, i_rd && o_valid};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue overflow");
    a_no_full_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd4) |-> !i_wr || (i_rd && o_valid)) else $error("write to full queue");
    a_space_meaning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_space |-> r_cnt != 3'd4) else $error("space flag wrong");
`endif

endmodule

FILE: src/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket framing: parse headers, unmask, tag payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one raw stream byte per request in s_axis_tdata.
//   m_axis: one result per request; tdata holds data_byte, has_byte,
//     msg_opcode, is_control, end_of_message, error_code from bit 0 up.
//   i_cfg_we/i_cfg_wdata write max_message_bytes; write only while idle.
// Throughput: one byte per cycle while s_axis_tready is high; the parser
//   handles each byte in the cycle it is accepted. A result is registered
//   between parser and queue and is written into the queue from there.
// A four-entry queue decouples the parser from the output; s_axis_tready
//   drops only when the queue holds three or more results, so a stalled
//   receiver backs up into the input without loss.
// Reset (synchronous, active low) clears parser state and the queue and sets
//   the limit to 16777216. After an error the block emits one error result
//   and then drops input bytes until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // data_byte[7:0], has_byte, msg_opcode[3:0],
                                        // is_control, end_of_message, error_code[2:0]
    input  logic        i_cfg_we,
    input  logic [24:0] i_cfg_wdata     // max_message_bytes
);

    logic [24:0] r_max;
    logic        w_acc;
    logic        w_res_valid;
    wsdf_pkg::t_result w_res;
    logic        r_q_wr;
    wsdf_pkg::t_result r_q_data;
    wsdf_pkg::t_result w_q_out;
    logic        w_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max <= 25'd16777216;
        else if (i_cfg_we) r_max <= i_cfg_wdata;
    end

    assign s_axis_tready = w_space;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    wsdf_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_byte_valid(w_acc), .i_byte(s_axis_tdata), .i_max_len(r_max),
        .o_res_valid(w_res_valid), .o_res(w_res)
    );

    // register between parser and queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_q_wr <= 1'b0;
        else          r_q_wr <= w_res_valid;
        r_q_data <= w_res;
    end

    wsdf_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(r_q_wr), .i_wr_data(r_q_data),
        .o_valid(m_axis_tvalid), .i_rd(m_axis_tready),
        .o_rd_data(w_q_out), .o_space(w_space)
    );

    assign m_axis_tdata = {6'd0, w_q_out.error_code, w_q_out.end_of_message,
                           w_q_out.is_control, w_q_out.msg_opcode,
                           w_q_out.has_byte, w_q_out.data_byte};

endmodule
